[src/assert_macros.svh]
// Assertion helpers used by the top-level RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check, disabled in reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication check, disabled in reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[src/fpl2_pkg.sv]
package fpl2_pkg;
   localparam int InputWidth = 64;
   localparam int FracBits   = 32;
   localparam int LogWidth   = 38;
   localparam int LeadWidth  = $clog2(InputWidth);
   localparam int MantWidth  = FracBits + 1;
   localparam int Stages     = FracBits;
   localparam int QueueDepth = 2;
   localparam int QueueAw    = $clog2(QueueDepth);

   typedef logic [MantWidth-1:0] mant_type;
   typedef logic [LeadWidth-1:0] lead_type;

   // Classified item passed from front to back.
   typedef struct packed {
      logic     zero;
      lead_type lead;
      mant_type mant;
   } item_type;
endpackage

[src/fpl2_front.sv]
module fpl2_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic [fpl2_pkg::InputWidth-1:0]   in_operand,
   output logic                              out_valid,
   output fpl2_pkg::item_type                out_item
);
   import fpl2_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   lead_type lead;
   logic [2*InputWidth-1:0] wide;

   // priority encoder for the top set bit
   always_comb begin
      lead = '0;
      for (int i = 0; i < InputWidth; i++) begin
         if (in_operand[i]) lead = LeadWidth'(i);
      end
   end

   always_comb begin
      // put the top bit at position InputWidth-1, then take FracBits+1 bits
      wide = {in_operand << (LeadWidth'(InputWidth - 1) - lead), {InputWidth{1'b0}}};
      item_in.zero = (in_operand == '0);
      item_in.lead = lead;
      item_in.mant = wide[2*InputWidth-1 -: MantWidth];
      valid_in     = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
endmodule

[src/fpl2_queue.sv]
module fpl2_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  fpl2_pkg::item_type push_item,
   output logic               pop_valid,
   output fpl2_pkg::item_type pop_item
);
   import fpl2_pkg::*;

   // Short FIFO; back end always drains, so entries leave next cycle.
   item_type mem_ff [QueueDepth];
   logic [QueueAw-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [QueueAw:0]   count_ff, count_in;
   logic               pop;

   assign pop_valid = (count_ff != '0);
   assign pop       = pop_valid;
   assign pop_item  = mem_ff[rptr_ff];

   always_comb begin
      wptr_in  = push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff + (QueueAw+1)'(push) - (QueueAw+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (push) mem_ff[wptr_ff] <= push_item;
   end
endmodule

[src/fpl2_back.sv]
module fpl2_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  fpl2_pkg::item_type              in_item,
   output logic                            out_valid,
   output logic [fpl2_pkg::LogWidth-1:0]   out_log,
   output logic                            out_zero
);
   import fpl2_pkg::*;

   // One squaring stage per fraction bit; entry s holds the output of stage s-1.
   logic     valid_ff [1:Stages];
   logic     zero_ff  [1:Stages];
   lead_type lead_ff  [1:Stages];
   mant_type mant_ff  [1:Stages];
   logic [FracBits-1:0] frac_ff [1:Stages];

   for (genvar s = 0; s < Stages; s++) begin : g_stage
      logic                   v_cur;
      logic                   z_cur;
      lead_type               l_cur;
      mant_type               m_cur;
      logic [FracBits-1:0]    f_cur;
      logic [2*MantWidth-1:0] sq;
      mant_type               scaled;
      logic                   ge_two;

      if (s == 0) begin : g_head
         assign v_cur = in_valid;
         assign z_cur = in_item.zero;
         assign l_cur = in_item.lead;
         assign m_cur = in_item.mant;
         assign f_cur = '0;
      end else begin : g_body
         assign v_cur = valid_ff[s];
         assign z_cur = zero_ff[s];
         assign l_cur = lead_ff[s];
         assign m_cur = mant_ff[s];
         assign f_cur = frac_ff[s];
      end

      assign sq     = m_cur * m_cur;
      assign ge_two = sq[2*MantWidth-1];
      assign scaled = ge_two ? sq[2*MantWidth-1 -: MantWidth]
                             : sq[2*MantWidth-2 -: MantWidth];
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s+1] <= 1'b0;
         end else begin
            valid_ff[s+1] <= v_cur;
         end
         zero_ff[s+1] <= z_cur;
         lead_ff[s+1] <= l_cur;
         mant_ff[s+1] <= scaled;
         frac_ff[s+1] <= f_cur | (ge_two ? FracBits'(1) << (FracBits-1-s) : '0);
      end
   end

   assign out_valid = valid_ff[Stages];
   assign out_zero  = zero_ff[Stages];
   assign out_log   = zero_ff[Stages] ? '0 :
                      LogWidth'({lead_ff[Stages], frac_ff[Stages]});
endmodule

[src/fixed_point_log2.sv]
// Channel  | Ports                                  | Transfer
// request  | start, busy, req_operand_value         | start && !busy
// response | rsp_valid, rsp_log_value, rsp_domain_error | rsp_valid (one cycle)
// Path: front register, queue, then 32 squaring stages.
// Rate: one item per cycle; one 33x33 multiplier per squaring stage.
// Reset is synchronous and clears only the valid flags and the queue pointers and count.
// busy is never raised; the receiver cannot stall, so nothing backs up.
module fixed_point_log2 (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [fpl2_pkg::InputWidth-1:0] req_operand_value,
   output logic                           rsp_valid,
   output logic [fpl2_pkg::LogWidth-1:0]  rsp_log_value,
   output logic                           rsp_domain_error
);
   import fpl2_pkg::*;
`include "assert_macros.svh"

   logic     front_valid, queue_valid, accept;
   item_type front_item, queue_item;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   fpl2_front u_front (
      .clock, .reset, .in_valid(accept), .in_operand(req_operand_value),
      .out_valid(front_valid), .out_item(front_item));

   fpl2_queue u_queue (
      .clock, .reset, .push(front_valid), .push_item(front_item),
      .pop_valid(queue_valid), .pop_item(queue_item));

   fpl2_back u_back (
      .clock, .reset, .in_valid(queue_valid), .in_item(queue_item),
      .out_valid(rsp_valid), .out_log(rsp_log_value), .out_zero(rsp_domain_error));

   `ASSERT_IMPL(a_err_zero, clock, reset, rsp_valid && rsp_domain_error, rsp_log_value == '0)
   `ASSERT_NEXT(a_front, clock, reset, accept, front_valid)
   `ASSERT_NEXT(a_queue, clock, reset, front_valid, queue_valid)
endmodule
